// ===== rtl/core/mouse_position_button_tracker_top_assert.svh =====
// ----------------------------------------------------------------------------
// Mouse tracker assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MOUSE_POSITION_BUTTON_TRACKER_TOP_ASSERT_SVH
`define MOUSE_POSITION_BUTTON_TRACKER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define MPBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MPBT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define MPBT_ASSERT(lbl, prop, msg)
`define MPBT_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== rtl/core/mpbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Mouse tracker package
// Request and response types, register indexes, widths and shared functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpbt_pkg;

  localparam int NUM_W     = 18;  // |delta| * 8 with delta saturated to 32000
  localparam int DIV_W     = 16;
  localparam int QUOT_W    = NUM_W + 1;
  localparam int POS_W     = 20;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int BTN_CNT   = 3;

  localparam logic signed [15:0] DELTA_LIM  = 16'sd32000;
  localparam logic signed [15:0] RST_MIN_X  = 16'sd0;
  localparam logic signed [15:0] RST_MAX_X  = 16'sd639;
  localparam logic signed [15:0] RST_MIN_Y  = 16'sd0;
  localparam logic signed [15:0] RST_MAX_Y  = 16'sd199;
  localparam logic [15:0]        RST_DIV_X  = 16'd8;
  localparam logic [15:0]        RST_DIV_Y  = 16'd16;
  localparam logic signed [15:0] RST_POS_X  = 16'sd320;
  localparam logic signed [15:0] RST_POS_Y  = 16'sd100;

  typedef enum logic [2:0] {
    ACT_MOTION       = 3'd0,
    ACT_SET_POS      = 3'd1,
    ACT_READ_PRESS   = 3'd2,
    ACT_READ_RELEASE = 3'd3,
    ACT_READ_MICKEYS = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    CFG_MIN_X   = 3'd0,
    CFG_MAX_X   = 3'd1,
    CFG_MIN_Y   = 3'd2,
    CFG_MAX_Y   = 3'd3,
    CFG_DIV_X   = 3'd4,
    CFG_DIV_Y   = 3'd5,
    CFG_X_SHIFT = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [7:0]         button_bits;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic [7:0]         button_index;
  } req_t;

  typedef struct packed {
    logic [6:0]  event_mask;
    logic [7:0]  buttons_now;
    logic [15:0] report_x;
    logic [15:0] report_y;
    logic [15:0] event_count;
    logic [15:0] mickeys_x;
    logic [15:0] mickeys_y;
  } rsp_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  function automatic logic signed [15:0] sat_delta(input logic signed [15:0] d);
    logic signed [15:0] r;
    r = d;
    if (d < -DELTA_LIM) r = -DELTA_LIM;
    else if (d > DELTA_LIM) r = DELTA_LIM;
    return r;
  endfunction

  // Limits are used in order even when software writes them swapped.
  function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [POS_W-1:0] v,
                                                         input logic signed [15:0] a,
                                                         input logic signed [15:0] b);
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
    logic signed [POS_W-1:0] r;
    if (a > b) begin
      lo = POS_W'(b);
      hi = POS_W'(a);
    end else begin
      lo = POS_W'(a);
      hi = POS_W'(b);
    end
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [15:0] shown_x(input logic [15:0] x, input logic xs);
    return xs ? {x[14:0], 1'b0} : x;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mouse_position_button_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Mouse position and button tracker
// Driver-side mouse state: motion scaling, clamping, button edge records.
// ----------------------------------------------------------------------------
// One request is handled at a time and always returns one response. A motion
// request with nonzero movement waits on two 18-step bit-serial dividers that
// run side by side to scale x and y; every other request goes straight to the
// finish state. The response sits in an output register, so the next request
// is taken while it waits to be read.
// Configuration writes take effect at once and should be made while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "mouse_position_button_tracker_top_assert.svh"

module mouse_position_button_tracker_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [2:0]     cfg_idx_i,
  input  wire logic [15:0]    cfg_wdata_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire mpbt_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mpbt_pkg::rsp_t      out_rsp_o
);
  import mpbt_pkg::*;

  // configuration
  logic signed [15:0] cfg_min_x_q, cfg_max_x_q, cfg_min_y_q, cfg_max_y_q;
  logic [15:0]        cfg_div_x_q, cfg_div_y_q;
  logic               cfg_xs_q;

  // architectural state
  logic signed [15:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [7:0]         btn_q, btn_d;
  logic [15:0]        mick_x_q, mick_x_d, mick_y_q, mick_y_d;
  logic [15:0]        press_cnt_q [BTN_CNT];
  logic [15:0]        press_cnt_d [BTN_CNT];
  logic [15:0]        rel_cnt_q   [BTN_CNT];
  logic [15:0]        rel_cnt_d   [BTN_CNT];
  logic [31:0]        press_pos_q [BTN_CNT];
  logic [31:0]        press_pos_d [BTN_CNT];
  logic [31:0]        rel_pos_q   [BTN_CNT];
  logic [31:0]        rel_pos_d   [BTN_CNT];

  // sequencing
  state_e             state_q, state_d;
  req_t               req_q;
  logic signed [15:0] dx_q, dy_q;
  logic               moved_q;
  logic               accept, commit, start;
  logic               out_valid_q;
  rsp_t               rsp_q, rsp_d;

  // request side
  logic signed [15:0] dx_in, dy_in, dx_abs, dy_abs;
  logic               in_motion, in_moved;
  div_req_t           div_x_req, div_y_req;
  logic               div_x_busy, div_y_busy, div_x_done, div_y_done;
  logic signed [QUOT_W-1:0] quot_x, quot_y;

  // finish datapath
  logic signed [POS_W-1:0] sum_x, sum_y, mv_x, mv_y, set_x, set_y;
  logic signed [15:0]      shifted_x;
  logic [31:0]             pack_pos, lat_pos;
  logic [1:0]              bsel;
  logic [6:0]              mask;
  logic [15:0]             count_out;
  logic                    act_motion, act_read;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_min_x_q <= RST_MIN_X;
      cfg_max_x_q <= RST_MAX_X;
      cfg_min_y_q <= RST_MIN_Y;
      cfg_max_y_q <= RST_MAX_Y;
      cfg_div_x_q <= RST_DIV_X;
      cfg_div_y_q <= RST_DIV_Y;
      cfg_xs_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_X:   cfg_min_x_q <= $signed(cfg_wdata_i);
        CFG_MAX_X:   cfg_max_x_q <= $signed(cfg_wdata_i);
        CFG_MIN_Y:   cfg_min_y_q <= $signed(cfg_wdata_i);
        CFG_MAX_Y:   cfg_max_y_q <= $signed(cfg_wdata_i);
        CFG_DIV_X:   cfg_div_x_q <= cfg_wdata_i;
        CFG_DIV_Y:   cfg_div_y_q <= cfg_wdata_i;
        CFG_X_SHIFT: cfg_xs_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request intake and divider launch
  // --------------------------------------------------------------------------
  assign dx_in     = sat_delta(in_req_i.delta_x);
  assign dy_in     = sat_delta(in_req_i.delta_y);
  assign dx_abs    = dx_in[15] ? -dx_in : dx_in;
  assign dy_abs    = dy_in[15] ? -dy_in : dy_in;
  assign in_motion = action_e'(in_req_i.action) == ACT_MOTION;
  assign in_moved  = (dx_in != 16'sd0) || (dy_in != 16'sd0);

  // A divisor register of zero falls back to its reset value.
  assign div_x_req = '{start:    start,
                       neg:      dx_in[15],
                       dividend: {dx_abs[14:0], 3'b000},
                       divisor:  (cfg_div_x_q == '0) ? RST_DIV_X : cfg_div_x_q};
  assign div_y_req = '{start:    start,
                       neg:      dy_in[15],
                       dividend: {dy_abs[14:0], 3'b000},
                       divisor:  (cfg_div_y_q == '0) ? RST_DIV_Y : cfg_div_y_q};

  mpbt_div u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_x_req),
    .busy_o (div_x_busy),
    .done_o (div_x_done),
    .quot_o (quot_x)
  );

  mpbt_div u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_y_req),
    .busy_o (div_y_busy),
    .done_o (div_y_done),
    .quot_o (quot_y)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = (in_motion && in_moved) ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_x_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    accept     = in_valid_i && in_ready_o;
    start      = accept && in_motion && in_moved;
    commit     = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= in_req_i;
      dx_q    <= dx_in;
      dy_q    <= dy_in;
      moved_q <= in_moved;
    end
    if (commit) rsp_q <= rsp_d;
  end

  // --------------------------------------------------------------------------
  // Finish: state update and response
  // --------------------------------------------------------------------------
  assign sum_x     = POS_W'(pos_x_q) + POS_W'(quot_x);
  assign sum_y     = POS_W'(pos_y_q) + POS_W'(quot_y);
  assign mv_x      = clamp_pos(sum_x, cfg_min_x_q, cfg_max_x_q);
  assign mv_y      = clamp_pos(sum_y, cfg_min_y_q, cfg_max_y_q);
  assign shifted_x = cfg_xs_q ? (req_q.new_x >>> 1) : req_q.new_x;
  assign set_x     = clamp_pos(POS_W'(shifted_x), cfg_min_x_q, cfg_max_x_q);
  assign set_y     = clamp_pos(POS_W'(req_q.new_y), cfg_min_y_q, cfg_max_y_q);
  assign bsel      = (req_q.button_index >= 8'd3) ? 2'd0 : req_q.button_index[1:0];
  assign act_motion = action_e'(req_q.action) == ACT_MOTION;
  assign act_read   = (action_e'(req_q.action) == ACT_READ_PRESS) ||
                      (action_e'(req_q.action) == ACT_READ_RELEASE);

  always_comb begin
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    btn_d     = btn_q;
    mick_x_d  = mick_x_q;
    mick_y_d  = mick_y_q;
    mask      = '0;
    count_out = '0;
    lat_pos   = '0;
    for (int k = 0; k < BTN_CNT; k++) begin
      press_cnt_d[k] = press_cnt_q[k];
      rel_cnt_d[k]   = rel_cnt_q[k];
      press_pos_d[k] = press_pos_q[k];
      rel_pos_d[k]   = rel_pos_q[k];
    end

    unique case (action_e'(req_q.action))
      ACT_MOTION: begin
        if (moved_q) begin
          pos_x_d  = mv_x[15:0];
          pos_y_d  = mv_y[15:0];
          mick_x_d = mick_x_q + dx_q;
          mick_y_d = mick_y_q + dy_q;
          mask[0]  = 1'b1;
        end
        btn_d = req_q.button_bits;
      end
      ACT_SET_POS: begin
        pos_x_d = set_x[15:0];
        pos_y_d = set_y[15:0];
      end
      ACT_READ_PRESS: begin
        count_out         = press_cnt_q[bsel];
        lat_pos           = press_pos_q[bsel];
        press_cnt_d[bsel] = '0;
      end
      ACT_READ_RELEASE: begin
        count_out       = rel_cnt_q[bsel];
        lat_pos         = rel_pos_q[bsel];
        rel_cnt_d[bsel] = '0;
      end
      ACT_READ_MICKEYS: begin
        mick_x_d = '0;
        mick_y_d = '0;
      end
      default: ;
    endcase

    // Button edges latch the position after this request's motion.
    pack_pos = {pos_y_d, pos_x_d};
    if (act_motion) begin
      for (int k = 0; k < BTN_CNT; k++) begin
        if (req_q.button_bits[k] != btn_q[k]) begin
          if (req_q.button_bits[k]) begin
            press_cnt_d[k]  = press_cnt_q[k] + 16'd1;
            press_pos_d[k]  = pack_pos;
            mask[1 + 2 * k] = 1'b1;
          end else begin
            rel_cnt_d[k]    = rel_cnt_q[k] + 16'd1;
            rel_pos_d[k]    = pack_pos;
            mask[2 + 2 * k] = 1'b1;
          end
        end
      end
    end

    rsp_d.event_mask  = mask;
    rsp_d.buttons_now = btn_d;
    rsp_d.report_x    = shown_x(act_read ? lat_pos[15:0] : pos_x_d, cfg_xs_q);
    rsp_d.report_y    = act_read ? lat_pos[31:16] : pos_y_d;
    rsp_d.event_count = count_out;
    // Reading the mickeys returns the counts from before they clear.
    rsp_d.mickeys_x   = act_motion ? mick_x_d : mick_x_q;
    rsp_d.mickeys_y   = act_motion ? mick_y_d : mick_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= RST_POS_X;
      pos_y_q  <= RST_POS_Y;
      btn_q    <= '0;
      mick_x_q <= '0;
      mick_y_q <= '0;
      for (int k = 0; k < BTN_CNT; k++) begin
        press_cnt_q[k] <= '0;
        rel_cnt_q[k]   <= '0;
        press_pos_q[k] <= '0;
        rel_pos_q[k]   <= '0;
      end
    end else if (commit) begin
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      btn_q    <= btn_d;
      mick_x_q <= mick_x_d;
      mick_y_q <= mick_y_d;
      for (int k = 0; k < BTN_CNT; k++) begin
        press_cnt_q[k] <= press_cnt_d[k];
        rel_cnt_q[k]   <= rel_cnt_d[k];
        press_pos_q[k] <= press_pos_d[k];
        rel_pos_q[k]   <= rel_pos_d[k];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MPBT_ASSERT(a_div_lockstep, (div_x_busy == div_y_busy) && (div_x_done == div_y_done), "x and y dividers out of step")
  `MPBT_ASSERT(a_idle_div_free, (state_q == ST_IDLE) |-> !div_x_busy, "divider busy while idle")
  `MPBT_ASSERT(a_div_motion, (state_q == ST_DIV) |-> (req_q.action == ACT_MOTION), "divide state for a non-motion request")
  `MPBT_ASSERT_NEXT(a_commit_loads, commit, out_valid_q, "finished request did not present a response")

endmodule

`default_nettype wire

// ===== rtl/core/mpbt_div.sv =====
// ----------------------------------------------------------------------------
// Mouse tracker serial divider
// Restoring divider, one quotient bit per cycle, signed result from magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpbt_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mpbt_pkg::div_req_t                  req_i,
  output logic                                     busy_o,
  output logic                                     done_o,
  output logic signed [mpbt_pkg::QUOT_W-1:0]       quot_o
);
  import mpbt_pkg::*;

  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  num_q;
  logic [DIV_W-1:0]  dsr_q;
  logic              neg_q;
  logic              busy_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DIV_W:0]    rem_sh, rem_sub;
  logic              qbit;
  logic [QUOT_W-1:0] mag;

  // Dividend bits leave at the top of num_q while quotient bits enter below.
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign qbit    = rem_sh >= {1'b0, dsr_q};
  assign rem_d   = qbit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= STEP_W'(DIV_STEPS - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      num_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[NUM_W-2:0], qbit};
    end
  end

  assign mag    = {1'b0, num_q};
  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = neg_q ? $signed(~mag + 1'b1) : $signed(mag);

endmodule

`default_nettype wire

// ===== tb/tb_mouse_position_button_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Mouse position and button tracker testbench
// Drives motion events and driver calls through the request channel under
// random bursts and output stalls. Every response is checked field by field
// against a behavioral model of the tracker kept inside the bench. The limit
// and scaling registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mouse_position_button_tracker_top;
  import mpbt_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req_data = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp_data;

  mouse_position_button_tracker_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_req_i    (req_data),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_rsp_o   (rsp_data)
  );

  always #4 clk = ~clk;

  // Register copies seen by the model.
  logic [15:0] lim_min_x, lim_max_x, lim_min_y, lim_max_y;
  logic [15:0] mickeys_div_x, mickeys_div_y;
  logic        x_doubled;

  // Tracker state copy.
  int          cur_x, cur_y;
  logic [7:0]  btn_state;
  logic [15:0] mick_x, mick_y;
  logic [15:0] press_cnt [3];
  logic [15:0] release_cnt [3];
  logic [31:0] press_at [3];
  logic [31:0] release_at [3];

  req_t driver_calls [$];
  rsp_t predicted_reports [$];
  int   mismatches = 0;
  int   reports_seen = 0;

  function automatic int limit_delta(logic [15:0] d);
    int v;
    v = $signed(d);
    if (v < -32000) v = -32000;
    if (v > 32000) v = 32000;
    return v;
  endfunction

  function automatic int fit_limits(int v, logic [15:0] a, logic [15:0] b);
    int lo;
    int hi;
    int t;
    lo = $signed(a);
    hi = $signed(b);
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic rsp_t mouse_report_for(req_t r);
    rsp_t        o;
    int          dx, dy, dvx, dvy, sel, nx;
    logic [7:0]  changed;
    logic [31:0] rec;
    logic [15:0] xv;
    o = '0;
    rec = '0;
    sel = (r.button_index >= 3) ? 0 : int'(r.button_index);
    o.mickeys_x = mick_x;
    o.mickeys_y = mick_y;
    case (r.action)
      ACT_MOTION: begin
        dx = limit_delta(r.delta_x);
        dy = limit_delta(r.delta_y);
        if (dx != 0 || dy != 0) begin
          dvx = (mickeys_div_x == 0) ? 8 : int'(mickeys_div_x);
          dvy = (mickeys_div_y == 0) ? 16 : int'(mickeys_div_y);
          mick_x = mick_x + 16'(dx);
          mick_y = mick_y + 16'(dy);
          cur_x = fit_limits(cur_x + (dx * 8) / dvx, lim_min_x, lim_max_x);
          cur_y = fit_limits(cur_y + (dy * 8) / dvy, lim_min_y, lim_max_y);
          o.event_mask[0] = 1'b1;
        end
        changed = r.button_bits ^ btn_state;
        for (int k = 0; k < 3; k++) begin
          if (changed[k]) begin
            if (r.button_bits[k]) begin
              press_cnt[k] = press_cnt[k] + 16'd1;
              press_at[k] = {16'(cur_y), 16'(cur_x)};
              o.event_mask = o.event_mask | 7'(2 << (2 * k));
            end else begin
              release_cnt[k] = release_cnt[k] + 16'd1;
              release_at[k] = {16'(cur_y), 16'(cur_x)};
              o.event_mask = o.event_mask | 7'(4 << (2 * k));
            end
          end
        end
        btn_state = r.button_bits;
        o.mickeys_x = mick_x;
        o.mickeys_y = mick_y;
      end
      ACT_SET_POS: begin
        nx = $signed(r.new_x);
        if (x_doubled) nx = nx >>> 1;
        cur_x = fit_limits(nx, lim_min_x, lim_max_x);
        cur_y = fit_limits($signed(r.new_y), lim_min_y, lim_max_y);
      end
      ACT_READ_PRESS: begin
        rec = press_at[sel];
        o.event_count = press_cnt[sel];
        press_cnt[sel] = '0;
      end
      ACT_READ_RELEASE: begin
        rec = release_at[sel];
        o.event_count = release_cnt[sel];
        release_cnt[sel] = '0;
      end
      ACT_READ_MICKEYS: begin
        mick_x = '0;
        mick_y = '0;
      end
      default: ;
    endcase
    o.buttons_now = btn_state;
    if (r.action == ACT_READ_PRESS || r.action == ACT_READ_RELEASE) begin
      xv = rec[15:0];
      o.report_y = rec[31:16];
    end else begin
      xv = 16'(cur_x);
      o.report_y = 16'(cur_y);
    end
    o.report_x = xv << x_doubled;
    return o;
  endfunction

  // Driver: bursts of requests separated by random gaps.
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) predicted_reports.push_back(mouse_report_for(req_data));
      if (!req_valid || req_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (driver_calls.size() > 0) begin
          req_data <= driver_calls.pop_front();
          req_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
          end else begin
            burst_left--;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] report %0d %s: expected %h, got %h", $time, reports_seen, name,
                 want, got);
    end
  endtask

  // Monitor: checks responses and drives the output stall pattern.
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_tick = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && rsp_valid && rsp_ready) begin
      reports_seen++;
      if (predicted_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("[%0t] response with no request waiting", $time);
      end else begin
        want = predicted_reports.pop_front();
        check_field("event_mask", 16'(want.event_mask), 16'(rsp_data.event_mask));
        check_field("buttons_now", 16'(want.buttons_now), 16'(rsp_data.buttons_now));
        check_field("report_x", want.report_x, rsp_data.report_x);
        check_field("report_y", want.report_y, rsp_data.report_y);
        check_field("event_count", want.event_count, rsp_data.event_count);
        check_field("mickeys_x", want.mickeys_x, rsp_data.mickeys_x);
        check_field("mickeys_y", want.mickeys_y, rsp_data.mickeys_y);
      end
    end
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    stall_tick++;
    if (stall_tick % 96 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0, 1: rsp_ready <= 1'b1;
        2: rsp_ready <= ($urandom_range(0, 2) != 0);
        default: rsp_ready <= (stall_tick % 11) < 6;
      endcase
    end
  end

  task automatic push_req(logic [2:0] act, logic [15:0] dx, logic [15:0] dy,
                          logic [7:0] bits, logic [15:0] nx, logic [15:0] ny,
                          logic [7:0] idx);
    req_t r;
    r.action = act;
    r.delta_x = dx;
    r.delta_y = dy;
    r.button_bits = bits;
    r.new_x = nx;
    r.new_y = ny;
    r.button_index = idx;
    driver_calls.push_back(r);
  endtask

  function automatic logic [15:0] random_delta();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return 16'($urandom);
      3: return 16'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(31900, 32768)));
      default: return 16'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) r.action = ACT_MOTION;
    else if (pick < 65) r.action = ACT_SET_POS;
    else if (pick < 75) r.action = ACT_READ_PRESS;
    else if (pick < 85) r.action = ACT_READ_RELEASE;
    else if (pick < 93) r.action = ACT_READ_MICKEYS;
    else r.action = 3'(int'(ACT_READ_MICKEYS) + $urandom_range(1, 3));
    r.delta_x = random_delta();
    r.delta_y = random_delta();
    r.button_bits = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    r.new_x = $urandom_range(0, 1) ? 16'($urandom) : 16'(int'($urandom_range(0, 2000)) - 1000);
    r.new_y = $urandom_range(0, 1) ? 16'($urandom) : 16'(int'($urandom_range(0, 2000)) - 1000);
    r.button_index = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    return r;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_MIN_X: lim_min_x = v;
      CFG_MAX_X: lim_max_x = v;
      CFG_MIN_Y: lim_min_y = v;
      CFG_MAX_Y: lim_max_y = v;
      CFG_DIV_X: mickeys_div_x = v;
      CFG_DIV_Y: mickeys_div_y = v;
      CFG_X_SHIFT: x_doubled = v[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [15:0] mnx, logic [15:0] mxx, logic [15:0] mny,
                               logic [15:0] mxy, logic [15:0] dvx, logic [15:0] dvy,
                               logic xs);
    write_reg(CFG_MIN_X, mnx);
    write_reg(CFG_MAX_X, mxx);
    write_reg(CFG_MIN_Y, mny);
    write_reg(CFG_MAX_Y, mxy);
    write_reg(CFG_DIV_X, dvx);
    write_reg(CFG_DIV_Y, dvy);
    write_reg(CFG_X_SHIFT, {15'd0, xs});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every request has been answered, then lets the block settle.
  task automatic wait_idle();
    while (driver_calls.size() != 0 || req_valid || predicted_reports.size() != 0)
      @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic run_phase(int n, bit long_hold);
    repeat (n) driver_calls.push_back(random_req());
    if (long_hold) hold_req = 1'b1;
    wait_idle();
  endtask

  initial begin
    lim_min_x = '0;
    lim_max_x = 16'd639;
    lim_min_y = '0;
    lim_max_y = 16'd199;
    mickeys_div_x = 16'd8;
    mickeys_div_y = 16'd16;
    x_doubled = 1'b0;
    cur_x = 320;
    cur_y = 100;
    btn_state = '0;
    mick_x = '0;
    mick_y = '0;
    for (int k = 0; k < 3; k++) begin
      press_cnt[k] = '0;
      release_cnt[k] = '0;
      press_at[k] = '0;
      release_at[k] = '0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings: saturation, edges, the out-of-range
    // button index, position extremes and the unused action codes.
    push_req(ACT_MOTION, 16'h7FFF, 16'h8000, 8'h01, '0, '0, '0);
    push_req(ACT_MOTION, 16'h8300, 16'h7D00, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    push_req(ACT_MOTION, '0, '0, 8'h00, '0, '0, '0);
    push_req(ACT_MOTION, '0, '0, 8'h00, '0, '0, '0);
    push_req(ACT_MOTION, 16'd5, -16'sd3, 8'h05, '0, '0, '0);
    push_req(ACT_MOTION, -16'sd1, 16'd1, 8'h07, '0, '0, '0);
    push_req(ACT_MOTION, 16'd32001, -16'sd32001, 8'hF8, '0, '0, '0);
    push_req(ACT_READ_PRESS, '0, '0, '0, '0, '0, 8'd0);
    push_req(ACT_READ_PRESS, '0, '0, '0, '0, '0, 8'd1);
    push_req(ACT_READ_PRESS, '0, '0, '0, '0, '0, 8'd2);
    push_req(ACT_READ_PRESS, '0, '0, '0, '0, '0, 8'd3);
    push_req(ACT_READ_RELEASE, '0, '0, '0, '0, '0, 8'd255);
    push_req(ACT_READ_RELEASE, '0, '0, '0, '0, '0, 8'd1);
    push_req(ACT_READ_RELEASE, '0, '0, '0, '0, '0, 8'd2);
    push_req(ACT_READ_RELEASE, '0, '0, '0, '0, '0, 8'd0);
    push_req(ACT_READ_MICKEYS, '0, '0, '0, '0, '0, '0);
    push_req(ACT_READ_MICKEYS, '0, '0, '0, '0, '0, '0);
    push_req(ACT_SET_POS, '0, '0, '0, 16'h7FFF, 16'h7FFF, '0);
    push_req(ACT_SET_POS, '0, '0, '0, 16'h8000, 16'h8000, '0);
    push_req(ACT_SET_POS, '0, '0, '0, 16'd100, 16'd50, '0);
    push_req(3'(int'(ACT_READ_MICKEYS) + 1), 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF,
             16'hFFFF, 8'h01);
    push_req(3'(int'(ACT_READ_MICKEYS) + 3), 16'h1234, 16'h4321, 8'h00, '0, '0, 8'h02);
    push_req(ACT_MOTION, '0, '0, 8'h02, '0, '0, '0);
    wait_idle();
    run_phase(150, 1'b0);

    // Widest limits and the smallest divisors.
    apply_setting(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd1, 16'd1, 1'b0);
    run_phase(196, 1'b0);
    // Swapped limits, zero divisors and doubled x.
    apply_setting(16'd500, -16'sd200, 16'd300, -16'sd50, 16'd0, 16'd0, 1'b1);
    run_phase(196, 1'b0);
    // Pinned position and the largest divisors, with a long output stall.
    apply_setting(16'd100, 16'd100, -16'sd7, -16'sd7, 16'hFFFF, 16'hFFFF, 1'b0);
    run_phase(196, 1'b1);
    apply_setting(16'd0, 16'd319, 16'd0, 16'd199, 16'd8, 16'd16, 1'b1);
    run_phase(196, 1'b0);
    apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 1'($urandom));
    run_phase(196, 1'b0);
    apply_setting(16'(int'($urandom_range(0, 4000)) - 2000),
                  16'(int'($urandom_range(0, 4000)) - 2000),
                  16'(int'($urandom_range(0, 4000)) - 2000),
                  16'(int'($urandom_range(0, 4000)) - 2000),
                  16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)), 1'($urandom));
    run_phase(196, 1'b0);
    // Swapped extremes.
    apply_setting(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd3, 16'd7, 1'b1);
    run_phase(196, 1'b0);

    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("tb_mouse_position_button_tracker_top passed");
    end else begin
      $display("tb_mouse_position_button_tracker_top failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_mouse_position_button_tracker_top failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mpbt_pkg.sv
rtl/core/mpbt_div.sv
rtl/core/mouse_position_button_tracker_top.sv
tb/tb_mouse_position_button_tracker_top.sv
